// File: hdl/assert_macros.svh
// Assertion macros of the CSV field parser, used by its datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/cfp_pkg.sv
// Package of the CSV field parser: word types, codes, command and status structs.
`default_nettype none

package cfp_pkg;

    // input word kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // result word kinds
    localparam logic [1:0] OUT_DATA       = 2'd0;
    localparam logic [1:0] OUT_FIELD_END  = 2'd1;
    localparam logic [1:0] OUT_LINE_END   = 2'd2;

    // characters
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] in_byte;
    } item_word_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [7:0] field_number;
        logic       trim_overflow;
        logic       truncated;
        logic       last_result;
    } result_word_t;

    // source of the next result word
    typedef enum logic [2:0] {
        SEL_BYTE,
        SEL_RD,
        SEL_HELD,
        SEL_FEND,
        SEL_LEND
    } out_sel_t;

    typedef struct packed {
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     len_inc;
        logic     field_end;
        logic     line_reset;
        logic     set_trunc;
        logic     set_ovf;
        logic     pend_push;
        logic     pend_rotate;
        logic     flush_start;
        logic     flush_next;
        logic     pend_clear;
    } cfp_cmd_t;

    typedef struct packed {
        logic item_eol;
        logic byte_ws;
        logic byte_quote;
        logic byte_semi;
        logic field_limit;
        logic len_full;
        logic len_last;
        logic pend_full;
        logic pend_empty;
        logic flush_more;
        logic held_valid;
        logic out_free;
    } cfp_status_t;

endpackage

`default_nettype wire

// File: hdl/cfp_datapath.sv
// Datapath of the CSV field parser: counters, pending whitespace store, output register.
`default_nettype none
`include "assert_macros.svh"

module cfp_datapath #(
    parameter int PENDING_DEPTH = 16,
    parameter int FIELD_BYTES   = 2048
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfp_pkg::item_word_t   item_data,
    input  wire logic                  cfg_valid,
    input  wire logic [7:0]            cfg_data,
    input  wire cfp_pkg::cfp_cmd_t     cmd,
    output      cfp_pkg::cfp_status_t  sts,
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    output      cfp_pkg::result_word_t result_data
);
    import cfp_pkg::*;

    localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int LEN_W = $clog2(FIELD_BYTES);
    localparam logic [LEN_W-1:0] LIMIT    = LEN_W'(FIELD_BYTES - 1);
    localparam logic [LEN_W-1:0] LIMIT_M1 = LEN_W'(FIELD_BYTES - 2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PENDING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PENDING_DEPTH);

    logic [7:0]       max_fields_reg, max_fields_next;
    logic [7:0]       field_count_reg, field_count_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             held_valid_reg, held_valid_next;
    logic             ovf_reg, ovf_next;
    logic             trunc_reg, trunc_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       held_reg;
    logic [7:0]       rd_reg;
    result_word_t     out_word_reg, out_word_next;

    logic [7:0]       pend_mem [PENDING_DEPTH];
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] head_inc;
    logic             pend_wr;
    logic             pend_rd;
    logic             out_free;
    logic [7:0]       in_byte;

    assign in_byte  = item_data.in_byte;
    assign out_free = !out_valid_reg || result_ready;

    // write slot is head + count, wrapped into the store
    always_comb
    begin
        wr_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (wr_sum >= SUM_W'(PENDING_DEPTH))
        begin
            wr_sum = wr_sum - SUM_W'(PENDING_DEPTH);
        end
        wr_addr  = wr_sum[PTR_W-1:0];
        head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    end

    assign pend_wr = cmd.pend_push || cmd.pend_rotate;
    assign pend_rd = cmd.pend_rotate || cmd.flush_start || cmd.flush_next;

    always_comb
    begin
        sts.item_eol    = (item_data.item_kind == KIND_EOL);
        sts.byte_ws     = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
        sts.byte_quote  = (in_byte == CH_QUOTE);
        sts.byte_semi   = (in_byte == CH_SEMI);
        sts.field_limit = (field_count_reg >= max_fields_reg);
        sts.len_full    = (len_reg == LIMIT);
        sts.len_last    = (len_reg == LIMIT_M1);
        sts.pend_full   = (count_reg == CNT_FULL);
        sts.pend_empty  = (count_reg == '0);
        sts.flush_more  = (remain_reg > CNT_W'(1));
        sts.held_valid  = held_valid_reg;
        sts.out_free    = out_free;
    end

    always_comb
    begin
        max_fields_next  = cfg_valid ? cfg_data : max_fields_reg;
        field_count_next = field_count_reg;
        len_next         = len_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        held_valid_next  = held_valid_reg;
        ovf_next         = ovf_reg;
        trunc_next       = trunc_reg;

        if (cmd.len_inc)
        begin
            len_next = len_reg + 1'b1;
        end
        if (cmd.set_trunc)
        begin
            trunc_next = 1'b1;
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.pend_push)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.pend_clear)
        begin
            count_next = '0;
        end
        if (cmd.pend_rotate)
        begin
            head_next       = head_inc;
            remain_next     = CNT_W'(1);
            held_valid_next = 1'b0;
        end
        if (cmd.flush_start)
        begin
            head_next       = head_inc;
            remain_next     = count_reg;
            count_next      = '0;
            held_valid_next = 1'b1;
        end
        if (cmd.flush_next)
        begin
            head_next   = head_inc;
            remain_next = remain_reg - 1'b1;
        end
        if (cmd.field_end || cmd.line_reset)
        begin
            field_count_next = cmd.line_reset ? 8'd0 : field_count_reg + 8'd1;
            len_next         = '0;
            count_next       = '0;
            ovf_next         = 1'b0;
            trunc_next       = 1'b0;
        end
    end

    // result word
    always_comb
    begin
        out_word_next = '0;
        out_word_next.field_number = field_count_reg;
        out_word_next.last_result  = cmd.out_last;
        case (cmd.out_sel)
            SEL_BYTE:
            begin
                out_word_next.out_kind = OUT_DATA;
                out_word_next.out_byte = in_byte;
            end
            SEL_RD:
            begin
                out_word_next.out_kind = OUT_DATA;
                out_word_next.out_byte = rd_reg;
            end
            SEL_HELD:
            begin
                out_word_next.out_kind = OUT_DATA;
                out_word_next.out_byte = held_reg;
            end
            SEL_FEND:
            begin
                out_word_next.out_kind      = OUT_FIELD_END;
                out_word_next.trim_overflow = ovf_reg;
                out_word_next.truncated     = trunc_reg;
            end
            SEL_LEND:
            begin
                out_word_next.out_kind = OUT_LINE_END;
            end
            default:
            begin
                out_word_next.out_kind = OUT_LINE_END;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fields_reg  <= MAX_FIELDS_RESET;
            field_count_reg <= '0;
            len_reg         <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
            remain_reg      <= '0;
            held_valid_reg  <= 1'b0;
            ovf_reg         <= 1'b0;
            trunc_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            max_fields_reg  <= max_fields_next;
            field_count_reg <= field_count_next;
            len_reg         <= len_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            remain_reg      <= remain_next;
            held_valid_reg  <= held_valid_next;
            ovf_reg         <= ovf_next;
            trunc_reg       <= trunc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word_reg <= out_word_next;
        end
        if (cmd.flush_start)
        begin
            held_reg <= in_byte;
        end
    end

    // pending whitespace store; read is old data on a same-slot write
    always_ff @(posedge clk)
    begin
        if (pend_wr)
        begin
            pend_mem[wr_addr] <= in_byte;
        end
        if (pend_rd)
        begin
            rd_reg <= pend_mem[head_reg];
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_word_reg;

    `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= CNT_FULL)
    `ASSERT_HOLDS(a_len_bound, clk, rst_n, len_reg <= LIMIT)
    `ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.out_load, out_free)
    `ASSERT_IMPLIES(a_held_room, clk, rst_n, cmd.out_load && cmd.out_sel == SEL_HELD, !sts.len_full)
    `ASSERT_NEXT(a_field_clear, clk, rst_n, cmd.field_end, count_reg == '0 && len_reg == '0)

endmodule

`default_nettype wire

// File: hdl/cfp_ctrl.sv
// Controller of the CSV field parser: parse mode and flush sequencing.
`default_nettype none

module cfp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output      logic                 item_ready,
    input  wire cfp_pkg::cfp_status_t sts,
    output      cfp_pkg::cfp_cmd_t    cmd
);
    import cfp_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_HELD,
        ST_EOL
    } state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_LEAD,
        MD_PLAIN,
        MD_QUOTED,
        MD_QEND,
        MD_SKIP
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    mode_t  mode_eff;
    logic   accept;
    logic   tail_left;

    // one data byte, or a truncation mark when the field is full
    function automatic cfp_cmd_t emit_cmd(input logic len_full);
        cfp_cmd_t c;
        c = '0;
        if (len_full)
        begin
            c.set_trunc = 1'b1;
        end
        else
        begin
            c.out_load = 1'b1;
            c.out_sel  = SEL_BYTE;
            c.out_last = 1'b1;
            c.len_inc  = 1'b1;
        end
        return c;
    endfunction

    function automatic cfp_cmd_t fend_cmd();
        cfp_cmd_t c;
        c = '0;
        c.out_load  = 1'b1;
        c.out_sel   = SEL_FEND;
        c.out_last  = 1'b1;
        c.field_end = 1'b1;
        return c;
    endfunction

    assign item_ready = (state_reg == ST_RUN) && sts.out_free;
    assign accept     = item_valid && item_ready;
    assign tail_left  = sts.flush_more || sts.held_valid;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        mode_next  = mode_reg;
        mode_eff   = mode_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (accept && sts.item_eol)
                begin
                    mode_next    = MD_IDLE;
                    cmd.out_load = 1'b1;
                    if (mode_reg != MD_IDLE)
                    begin
                        cmd.out_sel   = SEL_FEND;
                        cmd.field_end = 1'b1;
                        state_next    = ST_EOL;
                    end
                    else
                    begin
                        cmd.out_sel    = SEL_LEND;
                        cmd.out_last   = 1'b1;
                        cmd.line_reset = 1'b1;
                    end
                end
                else if (accept)
                begin
                    if (mode_reg == MD_IDLE)
                    begin
                        mode_eff = sts.field_limit ? MD_IDLE : MD_LEAD;
                    end
                    mode_next = mode_eff;
                    case (mode_eff)
                        MD_LEAD:
                        begin
                            if (sts.byte_ws)
                            begin
                                mode_next = MD_LEAD;
                            end
                            else if (sts.byte_quote)
                            begin
                                mode_next = MD_QUOTED;
                            end
                            else if (sts.byte_semi)
                            begin
                                cmd       = fend_cmd();
                                mode_next = MD_IDLE;
                            end
                            else
                            begin
                                cmd       = emit_cmd(sts.len_full);
                                mode_next = MD_PLAIN;
                            end
                        end
                        MD_PLAIN:
                        begin
                            if (sts.byte_ws && sts.pend_full)
                            begin
                                // full store: oldest byte goes out, new one takes its slot
                                cmd.pend_rotate = 1'b1;
                                cmd.set_ovf     = 1'b1;
                                if (sts.len_full)
                                begin
                                    cmd.set_trunc = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                            else if (sts.byte_ws)
                            begin
                                cmd.pend_push = 1'b1;
                            end
                            else if (sts.byte_semi)
                            begin
                                cmd       = fend_cmd();
                                mode_next = MD_IDLE;
                            end
                            else if (sts.pend_empty)
                            begin
                                cmd = emit_cmd(sts.len_full);
                            end
                            else if (sts.len_full)
                            begin
                                cmd.set_trunc  = 1'b1;
                                cmd.pend_clear = 1'b1;
                            end
                            else
                            begin
                                cmd.flush_start = 1'b1;
                                state_next      = ST_FLUSH;
                            end
                        end
                        MD_QUOTED:
                        begin
                            if (sts.byte_quote)
                            begin
                                mode_next = MD_QEND;
                            end
                            else
                            begin
                                cmd = emit_cmd(sts.len_full);
                            end
                        end
                        MD_QEND:
                        begin
                            if (sts.byte_quote)
                            begin
                                cmd       = emit_cmd(sts.len_full);
                                mode_next = MD_QUOTED;
                            end
                            else if (sts.byte_semi)
                            begin
                                cmd       = fend_cmd();
                                mode_next = MD_IDLE;
                            end
                            else
                            begin
                                mode_next = MD_SKIP;
                            end
                        end
                        MD_SKIP:
                        begin
                            if (sts.byte_semi)
                            begin
                                cmd       = fend_cmd();
                                mode_next = MD_IDLE;
                            end
                        end
                        default:
                        begin
                            mode_next = MD_IDLE;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_RD;
                    cmd.len_inc  = 1'b1;
                    cmd.out_last = !tail_left || sts.len_last;
                    if (sts.len_last && tail_left)
                    begin
                        // length limit reached: the rest is dropped
                        cmd.set_trunc = 1'b1;
                        state_next    = ST_RUN;
                    end
                    else if (sts.flush_more)
                    begin
                        cmd.flush_next = 1'b1;
                    end
                    else if (sts.held_valid)
                    begin
                        state_next = ST_HELD;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_HELD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_HELD;
                    cmd.out_last = 1'b1;
                    cmd.len_inc  = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_EOL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_LEND;
                    cmd.out_last   = 1'b1;
                    cmd.line_reset = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            mode_reg  <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/csv_field_parser.sv
// Top level of the CSV field parser: controller and datapath joined.
`default_nettype none

// Splits one text line, fed one byte word at a time, into fields separated by
// ';', with leading whitespace skipped, quoted fields ("" stands for one quote),
// and trailing whitespace of unquoted fields trimmed through a pending store of
// PENDING_DEPTH bytes. Each input word is followed by zero or more result words;
// last_result marks the final one. Rate: one input word per cycle in the common
// case, while the output is free. Pending whitespace released by a non-whitespace
// byte leaves, after that byte is accepted, one byte per cycle while the output
// is free, through the single read port of the pending store and the single
// output register; the releasing byte follows. An overflowing whitespace byte
// sends the oldest byte out unless the field is full; an end of line in an open
// field gives a field end, then a line end. The pending store needs no clearing
// pass after reset: only slots written in the current field are read. Write
// max_fields through the cfg channel only while idle; the block does not enforce
// it. cfg is always ready. Field data saturates at FIELD_BYTES-1 bytes per field.

module csv_field_parser #(
    parameter int PENDING_DEPTH = 16,
    parameter int FIELD_BYTES   = 2048
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input words
    input  wire logic                  item_valid,
    output      logic                  item_ready,
    input  wire cfp_pkg::item_word_t   item_data,
    // result words
    output      logic                  result_valid,
    input  wire logic                  result_ready,
    output      cfp_pkg::result_word_t result_data,
    // max_fields register write
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [7:0]            cfg_data
);
    import cfp_pkg::*;

    cfp_cmd_t    cmd;
    cfp_status_t sts;

    // register write never stalls
    assign cfg_ready = 1'b1;

    // Controller: parse mode per byte, plus the flush sequence that drains
    // pending whitespace ahead of the byte that released it.
    cfp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: field counters, pending store, output register.
    cfp_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .FIELD_BYTES   (FIELD_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_data    (item_data),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire
